>>> rtl/lli_message_deframer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the message deframer
// Shared helpers for concurrent checks clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LLI_MESSAGE_DEFRAMER_MACROS_SVH
`define LLI_MESSAGE_DEFRAMER_MACROS_SVH

// Concurrent check with a fixed failure text.
`define LMD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("deframer check failed");

// Concurrent check with a caller-supplied failure text.
`define LMD_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

>>> rtl/lmd_pkg.sv
// ----------------------------------------------------------------------------
// Message deframer package
// Command codes, result codes and the result record shared by the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lmd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned TYPE_W  = 3;
  localparam int unsigned PART_W  = 4;
  localparam int unsigned TUSER_W = TYPE_W + PART_W + 2;

  // Command bytes.
  localparam logic [BYTE_W-1:0] CMD_DATA_B3_IND = 8'h22;
  localparam logic [BYTE_W-1:0] CMD_MESSAGE     = 8'h21;
  localparam logic [BYTE_W-1:0] CMD_NEW_NCCI    = 8'h25;
  localparam logic [BYTE_W-1:0] CMD_FREE_NCCI   = 8'h26;
  localparam logic [BYTE_W-1:0] CMD_START       = 8'h23;
  localparam logic [BYTE_W-1:0] CMD_STOP        = 8'h24;
  localparam logic [BYTE_W-1:0] CMD_INIT        = 8'h27;

  // Message type codes.
  localparam logic [TYPE_W-1:0] MT_DATA_B3  = 3'd0;
  localparam logic [TYPE_W-1:0] MT_MESSAGE  = 3'd1;
  localparam logic [TYPE_W-1:0] MT_NEW_NCCI = 3'd2;
  localparam logic [TYPE_W-1:0] MT_FREE_NCCI = 3'd3;
  localparam logic [TYPE_W-1:0] MT_START    = 3'd4;
  localparam logic [TYPE_W-1:0] MT_STOP     = 3'd5;
  localparam logic [TYPE_W-1:0] MT_INIT     = 3'd6;
  localparam logic [TYPE_W-1:0] MT_UNKNOWN  = 3'd7;

  // Part codes.
  localparam logic [PART_W-1:0] PART_APPL     = 4'd0;
  localparam logic [PART_W-1:0] PART_NCCI     = 4'd1;
  localparam logic [PART_W-1:0] PART_WINDOW   = 4'd2;
  localparam logic [PART_W-1:0] PART_MSG_LEN  = 4'd3;
  localparam logic [PART_W-1:0] PART_MSG_BYTE = 4'd4;
  localparam logic [PART_W-1:0] PART_DATA_LEN = 4'd5;
  localparam logic [PART_W-1:0] PART_DATA_BYTE = 4'd6;
  localparam logic [PART_W-1:0] PART_VER_LEN  = 4'd7;
  localparam logic [PART_W-1:0] PART_VER_BYTE = 4'd8;
  localparam logic [PART_W-1:0] PART_CMD_ONLY = 4'd9;

  // One result of the deframer step.
  typedef struct packed {
    logic              valid;
    logic [TYPE_W-1:0] msg_type;
    logic [PART_W-1:0] part;
    logic [WORD_W-1:0] value;
    logic              last;
    logic              blocked;
    logic              card_live;
  } lmd_result_t;

endpackage

`default_nettype wire

>>> rtl/lli_message_deframer.sv
// A received byte is held in the input register until the step logic runs;
// a byte that yields a result then loads the result register, which shows
// it on the master side. The deframer takes one byte per cycle while the
// result register is free or being emptied downstream; a stalled result
// holds the flow. Reset (rst, synchronous, active high) empties both
// registers and returns the deframer to waiting for a command.
// ----------------------------------------------------------------------------
// Controller link message deframer
// Splits the controller's receive byte stream into words and payload bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module lli_message_deframer
  import lmd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,

  // Receive byte stream.
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [BYTE_W-1:0]  s_axis_tdata,   // [7:0] rx_byte

  // Result stream; tlast marks the final result of a message.
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [WORD_W-1:0]       m_axis_tdata,   // [31:0] value
  output logic                    m_axis_tlast,   // last
  output logic [TUSER_W-1:0]      m_axis_tuser    // [2:0] msg_type, [6:3] part,
                                                  // [7] blocked, [8] card_live
);

  // The input register holds one accepted byte. It is consumed in the cycle
  // the step logic runs, which happens whenever the result register is free
  // or is being emptied by the downstream side. A byte that completes no
  // result still advances the message state but leaves the output untouched.
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              advance;
  lmd_result_t       step_res;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  lmd_step u_step (
    .clk     (clk),
    .rst     (rst),
    .step_en (advance),
    .rx_byte (in_byte),
    .res     (step_res)
  );

  // Result register. A pending result holds until the downstream side takes
  // it; the step only runs when this register can accept what it produces.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance && step_res.valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_res.valid) begin
      m_axis_tdata <= step_res.value;
      m_axis_tlast <= step_res.last;
      m_axis_tuser <= {step_res.card_live, step_res.blocked,
                       step_res.part, step_res.msg_type};
    end
  end

endmodule

`default_nettype wire

>>> rtl/lmd_step.sv
// ----------------------------------------------------------------------------
// Deframer step
// Message state and the per-byte next-state and result logic.
// ----------------------------------------------------------------------------
`default_nettype none

module lmd_step
  import lmd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step_en,
  input  wire logic [BYTE_W-1:0] rx_byte,
  output lmd_result_t            res
);

  typedef enum logic [3:0] {
    PH_CMD     = 4'd0,
    PH_APPL    = 4'd1,
    PH_MSGLEN  = 4'd2,
    PH_MSG     = 4'd3,
    PH_DATALEN = 4'd4,
    PH_DATA    = 4'd5,
    PH_NCCI    = 4'd6,
    PH_WINDOW  = 4'd7,
    PH_VERLEN  = 4'd8,
    PH_VER     = 4'd9
  } phase_t;

  phase_t            phase, phase_next;
  logic [TYPE_W-1:0] cur_type, cur_type_next;
  logic [1:0]        byte_in_word, byte_in_word_next;
  logic [23:0]       word_acc, word_acc_next;
  logic [WORD_W-1:0] remaining, remaining_next;
  logic              stopped, stopped_next;
  logic              active, active_next;

  logic [WORD_W-1:0] word;
  logic [WORD_W-1:0] remaining_dec;
  logic              word_done;

  assign word          = {rx_byte, word_acc};
  assign remaining_dec = remaining - WORD_W'(1);
  assign word_done     = (byte_in_word == 2'd3);

  always_comb begin
    phase_next        = phase;
    cur_type_next     = cur_type;
    byte_in_word_next = byte_in_word;
    word_acc_next     = word_acc;
    remaining_next    = remaining;
    stopped_next      = stopped;
    active_next       = active;
    res.valid         = 1'b0;
    res.part          = PART_CMD_ONLY;
    res.value         = {{(WORD_W-BYTE_W){1'b0}}, rx_byte};
    res.last          = 1'b0;

    case (phase)
      PH_CMD: begin
        case (rx_byte)
          CMD_DATA_B3_IND: begin
            cur_type_next = MT_DATA_B3;
            phase_next    = PH_APPL;
          end
          CMD_MESSAGE: begin
            cur_type_next = MT_MESSAGE;
            phase_next    = PH_APPL;
          end
          CMD_NEW_NCCI: begin
            cur_type_next = MT_NEW_NCCI;
            phase_next    = PH_APPL;
          end
          CMD_FREE_NCCI: begin
            cur_type_next = MT_FREE_NCCI;
            phase_next    = PH_APPL;
          end
          CMD_INIT: begin
            cur_type_next = MT_INIT;
            phase_next    = PH_VERLEN;
          end
          CMD_START: begin
            cur_type_next = MT_START;
            stopped_next  = 1'b0;
            res.valid     = 1'b1;
            res.last      = 1'b1;
          end
          CMD_STOP: begin
            cur_type_next = MT_STOP;
            stopped_next  = 1'b1;
            res.valid     = 1'b1;
            res.last      = 1'b1;
          end
          default: begin
            cur_type_next = MT_UNKNOWN;
            res.valid     = 1'b1;
            res.last      = 1'b1;
          end
        endcase
      end

      PH_MSG, PH_DATA, PH_VER: begin
        res.valid      = 1'b1;
        remaining_next = remaining_dec;
        if (phase == PH_MSG) begin
          res.part = PART_MSG_BYTE;
        end else if (phase == PH_DATA) begin
          res.part = PART_DATA_BYTE;
        end else begin
          res.part = PART_VER_BYTE;
        end
        if (remaining_dec == '0) begin
          if (phase == PH_MSG && cur_type == MT_DATA_B3) begin
            phase_next = PH_DATALEN;
          end else begin
            if (phase == PH_VER) begin
              active_next = 1'b1;
            end
            phase_next = PH_CMD;
            res.last   = 1'b1;
          end
        end
      end

      PH_APPL, PH_MSGLEN, PH_DATALEN, PH_NCCI, PH_WINDOW, PH_VERLEN: begin
        if (!word_done) begin
          // Low three bytes collect in the accumulator, little end first.
          case (byte_in_word)
            2'd0:    word_acc_next[7:0]   = rx_byte;
            2'd1:    word_acc_next[15:8]  = rx_byte;
            default: word_acc_next[23:16] = rx_byte;
          endcase
          byte_in_word_next = byte_in_word + 2'd1;
        end else begin
          word_acc_next     = '0;
          byte_in_word_next = 2'd0;
          res.valid         = 1'b1;
          res.value         = word;
          case (phase)
            PH_APPL: begin
              res.part   = PART_APPL;
              phase_next = (cur_type <= MT_MESSAGE) ? PH_MSGLEN : PH_NCCI;
            end
            PH_NCCI: begin
              res.part = PART_NCCI;
              if (cur_type == MT_NEW_NCCI) begin
                phase_next = PH_WINDOW;
              end else begin
                phase_next = PH_CMD;
                res.last   = 1'b1;
              end
            end
            PH_WINDOW: begin
              res.part   = PART_WINDOW;
              phase_next = PH_CMD;
              res.last   = 1'b1;
            end
            PH_MSGLEN: begin
              res.part       = PART_MSG_LEN;
              remaining_next = word;
              if (word != '0) begin
                phase_next = PH_MSG;
              end else if (cur_type == MT_DATA_B3) begin
                phase_next = PH_DATALEN;
              end else begin
                phase_next = PH_CMD;
                res.last   = 1'b1;
              end
            end
            PH_DATALEN: begin
              res.part       = PART_DATA_LEN;
              remaining_next = word;
              if (word != '0) begin
                phase_next = PH_DATA;
              end else begin
                phase_next = PH_CMD;
                res.last   = 1'b1;
              end
            end
            default: begin
              res.part       = PART_VER_LEN;
              remaining_next = word;
              if (word != '0) begin
                phase_next = PH_VER;
              end else begin
                active_next = 1'b1;
                phase_next  = PH_CMD;
                res.last    = 1'b1;
              end
            end
          endcase
        end
      end

      default: begin
        phase_next = PH_CMD;
      end
    endcase

    // Flags in the result reflect the state after this byte.
    res.msg_type  = cur_type_next;
    res.blocked   = stopped_next;
    res.card_live = active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_CMD;
      cur_type     <= MT_DATA_B3;
      byte_in_word <= 2'd0;
      word_acc     <= '0;
      remaining    <= '0;
      stopped      <= 1'b0;
      active       <= 1'b0;
    end else if (step_en) begin
      phase        <= phase_next;
      cur_type     <= cur_type_next;
      byte_in_word <= byte_in_word_next;
      word_acc     <= word_acc_next;
      remaining    <= remaining_next;
      stopped      <= stopped_next;
      active       <= active_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/lmd_checker.sv
// ----------------------------------------------------------------------------
// Deframer port checker
// Checks result stream properties seen on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lli_message_deframer_macros.svh"

module lmd_checker
  import lmd_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               m_axis_tvalid,
  input wire logic               m_axis_tready,
  input wire logic [WORD_W-1:0]  m_axis_tdata,
  input wire logic               m_axis_tlast,
  input wire logic [TUSER_W-1:0] m_axis_tuser
);

  logic [TYPE_W-1:0] res_type;
  logic [PART_W-1:0] res_part;
  logic              res_blocked;
  logic              res_active;

  assign res_type    = m_axis_tuser[TYPE_W-1:0];
  assign res_part    = m_axis_tuser[TYPE_W+PART_W-1:TYPE_W];
  assign res_blocked = m_axis_tuser[TYPE_W+PART_W];
  assign res_active  = m_axis_tuser[TYPE_W+PART_W+1];

  // A stalled result keeps its contents.
  `LMD_ASSERT_MSG(a_stall_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "stalled result changed")

  // Once the card is active, every later result says so.
  `LMD_ASSERT(a_active_sticky, m_axis_tvalid && res_active |=> !m_axis_tvalid || res_active)

  // Command-only results, and only they, come from unknown, start and stop.
  `LMD_ASSERT(a_cmd_only_last, m_axis_tvalid && res_part == PART_CMD_ONLY |-> m_axis_tlast && (res_type == MT_START || res_type == MT_STOP || res_type == MT_UNKNOWN))

  // Start clears and stop sets the blocked flag in its own result.
  `LMD_ASSERT(a_flow_flag, m_axis_tvalid && res_part == PART_CMD_ONLY && (res_type == MT_START || res_type == MT_STOP) |-> res_blocked == (res_type == MT_STOP))

  // Unknown commands carry a value no wider than the command byte.
  `LMD_ASSERT(a_unknown_byte, m_axis_tvalid && res_type == MT_UNKNOWN |-> res_part == PART_CMD_ONLY && m_axis_tdata[WORD_W-1:BYTE_W] == '0)

endmodule

bind lli_message_deframer lmd_checker u_lmd_checker (.*);

`default_nettype wire
